>>> hw/rtl/nlneg_pkg.sv
// Package for the name-list negotiator: transaction structs, operation codes
// and list constants. Depends on nothing.
package nlneg_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_SERVER = 2'd1;
    localparam logic [1:0] OP_CLIENT = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    // List separator and saturation limit of the reported indices
    localparam logic [7:0]  LIST_COMMA = 8'h2C;
    localparam logic [11:0] INDEX_MAX  = 12'hFFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [11:0] server_word_index;
        logic [11:0] client_word_index;
        logic        overflow;
    } out_t;

endpackage

>>> hw/rtl/name_list_negotiator.sv
// Name-list negotiator top level: server list store, client piece buffer and
// the sequencer that walks the server store for each finished client piece.
// Depends on nlneg_pkg.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+--------------------------------
//  in      | to block  | in_valid/in_stall   | in_data  (operation, data_byte)
//  out     | from block| out_valid/out_stall | out_data (found, indices, overflow)
//
// Clears, appends and client bytes inside a piece are taken while idle. A client
// piece that ends (comma or list end) walks the server store through its single
// read port, with a read state and an evaluate state per stored byte, unless a
// match is already held or the piece overflowed. List end then waits for the output register to be free.
// Reset clears all control state at once; the two memories need no clearing.
// in_stall is high whenever the sequencer is not idle.
module name_list_negotiator #(
    parameter int SERVER_DEPTH = 2048,
    parameter int PIECE_DEPTH  = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  nlneg_pkg::in_t   in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output nlneg_pkg::out_t  out_data
);
    import nlneg_pkg::*;

    localparam int SA  = $clog2(SERVER_DEPTH);
    localparam int SLW = $clog2(SERVER_DEPTH + 1);
    localparam int PA  = $clog2(PIECE_DEPTH);
    localparam int KW  = $clog2(PIECE_DEPTH + 1);
    localparam int WW  = (SLW > 12) ? SLW : 12;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_EVAL   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    // Memories
    logic [7:0] server_mem [SERVER_DEPTH];
    logic [7:0] piece_mem  [PIECE_DEPTH];
    logic [7:0] srv_rd;
    logic [7:0] pc_rd;
    logic       srv_we;
    logic       pc_we;

    // Control state
    logic [1:0]     state_reg, state_next;
    logic [SLW-1:0] srv_len_reg, srv_len_next;
    logic [KW-1:0]  plen_reg, plen_next;
    logic           over_reg, over_next;
    logic [11:0]    count_reg, count_next;
    logic           start_reg, start_next;
    logic           match_reg, match_next;
    logic [11:0]    midx_reg, midx_next;
    logic           ovf_reg, ovf_next;
    logic           fin_end_reg, fin_end_next;
    logic [SLW-1:0] pos_reg, pos_next;
    logic [KW-1:0]  k_reg, k_next;
    logic           mism_reg, mism_next;
    logic           skip_reg, skip_next;
    logic [WW-1:0]  word_reg, word_next;
    logic           out_valid_reg, out_valid_next;
    out_t           out_data_reg, out_data_next;

    logic           accept;
    logic           out_free;
    logic           is_comma;
    logic           hit;
    logic           walk_done;
    logic [11:0]    word_sat;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_comma  = (srv_rd == LIST_COMMA);
    assign word_sat  = (word_reg > WW'(INDEX_MAX)) ? INDEX_MAX : word_reg[11:0];

    assign srv_we = accept && (in_data.operation == OP_SERVER)
                    && (srv_len_reg < SLW'(SERVER_DEPTH));
    assign pc_we  = accept && (in_data.operation == OP_CLIENT)
                    && !(start_reg ? 1'b0 : (in_data.data_byte == LIST_COMMA))
                    && !(start_reg && (in_data.data_byte == LIST_COMMA))
                    && (plen_reg < KW'(PIECE_DEPTH));

    // Write on load, read at the walk position every cycle
    always_ff @(posedge clk)
    begin
        if (srv_we)
        begin
            server_mem[srv_len_reg[SA-1:0]] <= in_data.data_byte;
        end
        srv_rd <= server_mem[pos_reg[SA-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pc_we)
        begin
            piece_mem[plen_reg[PA-1:0]] <= in_data.data_byte;
        end
        pc_rd <= piece_mem[k_reg[PA-1:0]];
    end

    // Sequencer and bookkeeping
    always_comb
    begin
        state_next     = state_reg;
        srv_len_next   = srv_len_reg;
        plen_next      = plen_reg;
        over_next      = over_reg;
        count_next     = count_reg;
        start_next     = start_reg;
        match_next     = match_reg;
        midx_next      = midx_reg;
        ovf_next       = ovf_reg;
        fin_end_next   = fin_end_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        mism_next      = mism_reg;
        skip_next      = skip_reg;
        word_next      = word_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        hit            = 1'b0;
        walk_done      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.operation)
                        OP_CLEAR:
                        begin
                            srv_len_next = '0;
                            ovf_next     = 1'b0;
                        end
                        OP_SERVER:
                        begin
                            if (srv_len_reg < SLW'(SERVER_DEPTH))
                                srv_len_next = srv_len_reg + 1'b1;
                            else
                                ovf_next = 1'b1;
                        end
                        OP_CLIENT:
                        begin
                            if (start_reg && (in_data.data_byte == LIST_COMMA))
                            begin
                                start_next = 1'b0;
                            end
                            else if (!start_reg && (in_data.data_byte == LIST_COMMA))
                            begin
                                // Piece ends: unless a match is held, count it and walk the server list if it fit
                                plen_next = '0;
                                over_next = 1'b0;
                                if (!match_reg)
                                begin
                                    if (count_reg != INDEX_MAX)
                                        count_next = count_reg + 1'b1;
                                    if (!over_reg)
                                    begin
                                        plen_next    = plen_reg;
                                        fin_end_next = 1'b0;
                                        state_next   = ST_READ;
                                    end
                                end
                            end
                            else
                            begin
                                start_next = 1'b0;
                                if (plen_reg < KW'(PIECE_DEPTH))
                                    plen_next = plen_reg + 1'b1;
                                else if (!over_reg)
                                begin
                                    // Flag overflow only on the first dropped byte
                                    over_next = 1'b1;
                                    ovf_next  = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            // List end: close the last piece, then report
                            state_next = ST_RESULT;
                            if (!start_reg && !match_reg)
                            begin
                                if (count_reg != INDEX_MAX)
                                    count_next = count_reg + 1'b1;
                                if (!over_reg)
                                begin
                                    fin_end_next = 1'b1;
                                    state_next   = ST_READ;
                                end
                            end
                        end
                    endcase
                    pos_next  = '0;
                    k_next    = '0;
                    mism_next = 1'b0;
                    skip_next = 1'b0;
                    word_next = WW'(1);
                end
            end

            ST_READ:
            begin
                if (pos_reg >= srv_len_reg)
                begin
                    walk_done = 1'b1;
                    hit       = !skip_reg && !mism_reg && (k_reg == plen_reg);
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                pos_next   = pos_reg + 1'b1;
                state_next = ST_READ;
                if (!skip_reg)
                begin
                    if (is_comma)
                    begin
                        if (!mism_reg && (k_reg == plen_reg))
                        begin
                            walk_done = 1'b1;
                            hit       = 1'b1;
                        end
                        else
                        begin
                            skip_next = 1'b1;
                            k_next    = '0;
                        end
                    end
                    else if (k_reg < plen_reg)
                    begin
                        mism_next = mism_reg || (srv_rd != pc_rd);
                        k_next    = k_reg + 1'b1;
                    end
                    else
                    begin
                        mism_next = 1'b1;
                    end
                end
                else if (!is_comma)
                begin
                    // First byte of the next word, compared with piece byte zero
                    skip_next = 1'b0;
                    word_next = word_reg + 1'b1;
                    if (plen_reg != '0)
                    begin
                        mism_next = (srv_rd != pc_rd);
                        k_next    = KW'(1);
                    end
                    else
                    begin
                        mism_next = 1'b1;
                        k_next    = '0;
                    end
                end
            end

            default:
            begin
                // Report once the output register is free, then drop client state
                if (out_free)
                begin
                    out_valid_next                  = 1'b1;
                    out_data_next.found             = match_reg;
                    out_data_next.server_word_index = match_reg ? midx_reg : 12'd0;
                    out_data_next.client_word_index = match_reg ? count_reg : 12'd0;
                    out_data_next.overflow          = ovf_reg;
                    plen_next  = '0;
                    over_next  = 1'b0;
                    count_next = '0;
                    start_next = 1'b1;
                    match_next = 1'b0;
                    midx_next  = '0;
                    state_next = ST_IDLE;
                end
            end
        endcase

        // Close the walk: record a hit and release the piece
        if (walk_done)
        begin
            if (hit)
            begin
                match_next = 1'b1;
                midx_next  = word_sat;
            end
            plen_next  = '0;
            over_next  = 1'b0;
            state_next = fin_end_reg ? ST_RESULT : ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            srv_len_reg   <= '0;
            plen_reg      <= '0;
            over_reg      <= 1'b0;
            count_reg     <= '0;
            start_reg     <= 1'b1;
            match_reg     <= 1'b0;
            midx_reg      <= '0;
            ovf_reg       <= 1'b0;
            fin_end_reg   <= 1'b0;
            pos_reg       <= '0;
            k_reg         <= '0;
            mism_reg      <= 1'b0;
            skip_reg      <= 1'b0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            srv_len_reg   <= srv_len_next;
            plen_reg      <= plen_next;
            over_reg      <= over_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            match_reg     <= match_next;
            midx_reg      <= midx_next;
            ovf_reg       <= ovf_next;
            fin_end_reg   <= fin_end_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            mism_reg      <= mism_next;
            skip_reg      <= skip_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output transaction payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

>>> bench/negotiation_checker.sv
// Checker for the name-list negotiator: follows both channels, predicts each
// negotiation outcome from its own copy of the lists and compares field by field.
// Depends on nlneg_pkg.
module negotiation_checker #(
    parameter int SERVER_DEPTH = 2048,
    parameter int PIECE_DEPTH  = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_stall,
    input  nlneg_pkg::in_t  in_data,
    input  logic            out_valid,
    input  logic            out_stall,
    input  nlneg_pkg::out_t out_data,
    output int              fail_count,
    output int              outcomes_pending
);
    import nlneg_pkg::*;

    localparam int unsigned OVERLONG = PIECE_DEPTH + 1;

    // Shadow of the server list and of the client piece being collected
    logic [7:0]  server_bytes [SERVER_DEPTH];
    int unsigned server_len;
    logic [7:0]  piece_bytes [PIECE_DEPTH];
    int unsigned piece_len;
    int unsigned piece_total;
    int unsigned matched_word;
    bit          list_fresh;
    bit          have_match;
    bit          overflow_flag;
    out_t        outcome_q [$];

    // Return the 1-based server word equal to the current piece, 0 if none
    function automatic int unsigned find_server_word();
        int unsigned pos;
        int unsigned stop;
        int unsigned word;
        bit          same;
        if (piece_len > PIECE_DEPTH)
            return 0;
        pos  = 0;
        word = 1;
        forever
        begin
            stop = pos;
            while (stop < server_len && server_bytes[stop] != LIST_COMMA)
                stop++;
            if (stop - pos == piece_len)
            begin
                same = 1'b1;
                for (int unsigned k = 0; k < piece_len; k++)
                    if (server_bytes[pos + k] != piece_bytes[k])
                        same = 1'b0;
                if (same)
                    return word;
            end
            // Skip the run of commas; a run at the very end starts no word
            pos = stop;
            while (pos < server_len && server_bytes[pos] == LIST_COMMA)
                pos++;
            if (pos >= server_len)
                return 0;
            word++;
        end
    endfunction

    // Count and compare a finished piece unless a match is already held
    function automatic void close_piece();
        int unsigned w;
        if (!have_match)
        begin
            if (piece_total < INDEX_MAX)
                piece_total++;
            w = find_server_word();
            if (w != 0)
            begin
                have_match   = 1'b1;
                matched_word = (w > INDEX_MAX) ? INDEX_MAX : w;
            end
        end
        piece_len = 0;
    endfunction

    function automatic void clear_client();
        piece_len    = 0;
        piece_total  = 0;
        list_fresh   = 1'b1;
        have_match   = 1'b0;
        matched_word = 0;
    endfunction

    // Advance the shadow state by one input transaction
    function automatic void apply_item(input in_t item);
        out_t outcome;
        case (item.operation)
            OP_CLEAR:
            begin
                server_len    = 0;
                overflow_flag = 1'b0;
            end
            OP_SERVER:
            begin
                if (server_len < SERVER_DEPTH)
                begin
                    server_bytes[server_len] = item.data_byte;
                    server_len++;
                end
                else
                    overflow_flag = 1'b1;
            end
            OP_CLIENT:
            begin
                if (list_fresh && item.data_byte == LIST_COMMA)
                    list_fresh = 1'b0;
                else if (!list_fresh && item.data_byte == LIST_COMMA)
                    close_piece();
                else
                begin
                    list_fresh = 1'b0;
                    if (piece_len < PIECE_DEPTH)
                    begin
                        piece_bytes[piece_len] = item.data_byte;
                        piece_len++;
                    end
                    else if (piece_len == PIECE_DEPTH)
                    begin
                        piece_len     = OVERLONG;
                        overflow_flag = 1'b1;
                    end
                end
            end
            OP_END:
            begin
                if (!list_fresh)
                    close_piece();
                outcome.found             = have_match;
                outcome.server_word_index = have_match ? matched_word[11:0] : 12'd0;
                outcome.client_word_index = have_match ? piece_total[11:0] : 12'd0;
                outcome.overflow          = overflow_flag;
                outcome_q.push_back(outcome);
                clear_client();
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [11:0] want,
                                        input logic [11:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare a result transaction with the oldest outcome waiting
    function automatic void compare_outcome(input out_t got);
        out_t want;
        if (outcome_q.size() == 0)
        begin
            $error("result transaction with no outcome waiting");
            fail_count++;
            return;
        end
        want = outcome_q.pop_front();
        check_field("found", 12'(want.found), 12'(got.found));
        check_field("server_word_index", want.server_word_index, got.server_word_index);
        check_field("client_word_index", want.client_word_index, got.client_word_index);
        check_field("overflow", 12'(want.overflow), 12'(got.overflow));
    endfunction

    // Check results before taking new input: a result never answers the
    // list end accepted at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_len    = 0;
            overflow_flag = 1'b0;
            clear_client();
            outcome_q.delete();
            outcomes_pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                compare_outcome(out_data);
            if (in_valid && !in_stall)
                apply_item(in_data);
            outcomes_pending <= outcome_q.size();
        end
    end

endmodule

>>> bench/testbench.sv
// Top of the name-list negotiator bench: clock, reset, list stimulus and the
// verdict. Depends on nlneg_pkg, name_list_negotiator and negotiation_checker.
module testbench;
    import nlneg_pkg::*;

    localparam int SERVER_DEPTH = 2048;
    localparam int PIECE_DEPTH  = 64;
    localparam int VOCAB_SIZE   = 12;
    localparam int ITEM_GOAL    = 850;
    localparam int OUTCOME_GOAL = 50;
    localparam int QUIET_LIMIT  = 50000;
    localparam int DRAIN_CYCLES = 100;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    in_t  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    out_t out_data;

    int fail_count;
    int outcomes_pending;
    int items_sent   = 0;
    int bulk_items   = 0;
    int ends_sent    = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;

    name_list_negotiator #(
        .SERVER_DEPTH(SERVER_DEPTH),
        .PIECE_DEPTH (PIECE_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    negotiation_checker #(
        .SERVER_DEPTH(SERVER_DEPTH),
        .PIECE_DEPTH (PIECE_DEPTH)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .fail_count      (fail_count),
        .outcomes_pending(outcomes_pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Small vocabulary so that client pieces often hit server words
    function automatic string vocab_word(input int unsigned k);
        case (k)
            0:       return "";
            1:       return "a";
            2:       return "ab";
            3:       return "abc";
            4:       return "b";
            5:       return "ba";
            6:       return "ssh-rsa";
            7:       return "ssh-ed25519";
            8:       return "aes128-ctr";
            9:       return "aes128-gcm";
            10:      return "none";
            default: return "zz";
        endcase
    endfunction

    function automatic bit idle_roll();
        return !calm && ($urandom_range(99) < 9);
    endfunction

    // Drive one input transaction and hold it until accepted
    task automatic push_item(input logic [1:0] op, input logic [7:0] value);
        in_t item;
        item.operation = op;
        item.data_byte = value;
        while (idle_roll())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        items_sent++;
        if (op == OP_END)
            ends_sent++;
    endtask

    task automatic send_text(input logic [1:0] op, input string text);
        for (int i = 0; i < text.len(); i++)
            push_item(op, text[i]);
    endtask

    // Reload the server list: optional leading comma, comma runs, trailing comma
    task automatic send_server_list();
        int n;
        n = $urandom_range(0, 6);
        push_item(OP_CLEAR, 8'($urandom_range(255)));
        if ($urandom_range(5) == 0)
            push_item(OP_SERVER, LIST_COMMA);
        for (int w = 0; w < n; w++)
        begin
            if (w > 0)
                repeat (($urandom_range(3) == 0) ? 2 : 1)
                    push_item(OP_SERVER, LIST_COMMA);
            send_text(OP_SERVER, vocab_word($urandom_range(1, VOCAB_SIZE - 1)));
        end
        if ($urandom_range(4) == 0)
            push_item(OP_SERVER, LIST_COMMA);
    endtask

    // Stream a client list, now and then touching the server list mid-way
    task automatic send_client_list();
        int n;
        n = $urandom_range(0, 6);
        if ($urandom_range(4) == 0)
            push_item(OP_CLIENT, LIST_COMMA);
        for (int p = 0; p < n; p++)
        begin
            if (p > 0)
                push_item(OP_CLIENT, LIST_COMMA);
            if ($urandom_range(11) == 0)
            begin
                if ($urandom_range(1) == 0)
                    push_item(OP_SERVER, 8'($urandom_range(255)));
                else
                    push_item(OP_CLEAR, 8'($urandom_range(255)));
            end
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 4))
                    push_item(OP_CLIENT, 8'($urandom_range(255)));
            else
                send_text(OP_CLIENT, vocab_word($urandom_range(VOCAB_SIZE - 1)));
        end
        if ($urandom_range(7) == 0)
            push_item(OP_CLIENT, LIST_COMMA);
        push_item(OP_END, 8'($urandom_range(255)));
    endtask

    // Pieces around the buffer depth: one byte longer first, then the exact word
    task automatic send_long_word_case();
        int span;
        span = $urandom_range(PIECE_DEPTH - 2, PIECE_DEPTH + 2);
        push_item(OP_CLEAR, 8'($urandom_range(255)));
        send_text(OP_SERVER, "ab,");
        for (int i = 0; i < span; i++)
            push_item(OP_SERVER, 8'h61 + 8'(i % 26));
        for (int i = 0; i <= span; i++)
            push_item(OP_CLIENT, 8'h61 + 8'(i % 26));
        push_item(OP_CLIENT, LIST_COMMA);
        for (int i = 0; i < span; i++)
            push_item(OP_CLIENT, 8'h61 + 8'(i % 26));
        push_item(OP_END, 8'($urandom_range(255)));
    endtask

    // Fill the server store to the last byte and spill past it
    task automatic send_full_server_case();
        int    fill;
        string s;
        fill = 0;
        push_item(OP_CLEAR, 8'($urandom_range(255)));
        while (fill < SERVER_DEPTH - 20)
        begin
            s = vocab_word($urandom_range(1, VOCAB_SIZE - 1));
            send_text(OP_SERVER, s);
            push_item(OP_SERVER, LIST_COMMA);
            fill += s.len() + 1;
        end
        while (fill < SERVER_DEPTH - 6)
        begin
            push_item(OP_SERVER, LIST_COMMA);
            fill++;
        end
        send_text(OP_SERVER, "tail,q");
        send_text(OP_SERVER, "spill");
        send_text(OP_CLIENT, "nope,tail,q");
        push_item(OP_END, 8'($urandom_range(255)));
        send_text(OP_CLIENT, "q");
        push_item(OP_END, 8'($urandom_range(255)));
        push_item(OP_CLEAR, 8'($urandom_range(255)));
    endtask

    // Run the client piece count past its saturation point before a match
    task automatic send_piece_count_case();
        push_item(OP_CLEAR, 8'($urandom_range(255)));
        push_item(OP_SERVER, 8'h78);
        repeat (int'(INDEX_MAX) + 5)
            push_item(OP_CLIENT, LIST_COMMA);
        push_item(OP_CLIENT, 8'h78);
        push_item(OP_END, 8'($urandom_range(255)));
    endtask

    // Stall the result channel at random
    always @(negedge clk)
        out_stall <= idle_roll();

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        int round;
        int pick;
        int mark;
        round = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty client list straight after reset
        push_item(OP_END, 8'hFF);
        // Empty server list holds one empty word, matched by an empty piece
        push_item(OP_CLIENT, LIST_COMMA);
        push_item(OP_CLIENT, LIST_COMMA);
        push_item(OP_END, 8'h00);
        // Leading comma and comma run on the server side
        push_item(OP_CLEAR, 8'hFF);
        send_text(OP_SERVER, ",ab,,c");
        send_text(OP_CLIENT, "c,ab");
        push_item(OP_END, 8'h00);
        // Trailing comma gives an empty last piece
        send_text(OP_CLIENT, "zz,");
        push_item(OP_END, 8'hA5);

        // Random sessions, mostly well-formed negotiations
        while (items_sent - bulk_items < ITEM_GOAL || ends_sent < OUTCOME_GOAL)
        begin
            calm = (round >= 15 && round < 25);
            if (round == 3 || round == 10)
            begin
                mark = items_sent;
                if (round == 3)
                    send_piece_count_case();
                else
                    send_full_server_case();
                bulk_items += items_sent - mark;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    repeat ($urandom_range(1, 8))
                        push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
                else if (pick < 14)
                    send_long_word_case();
                else
                begin
                    if ($urandom_range(3) != 0)
                        send_server_list();
                    send_client_list();
                end
            end
            round++;
        end
        calm = 1'b0;
        push_item(OP_END, 8'($urandom_range(255)));
        in_valid <= 1'b0;

        // Drain the outstanding outcomes, then watch for strays
        while (outcomes_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/nlneg_pkg.sv
hw/rtl/name_list_negotiator.sv
bench/negotiation_checker.sv
bench/testbench.sv
